// ----- design/event_timer_table_macros.svh -----
`ifndef EVENT_TIMER_TABLE_MACROS_SVH
`define EVENT_TIMER_TABLE_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ETT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ETT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/ett_pkg.sv -----
`default_nettype none

package ett_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_RESULTS   = 16;
    localparam int CNT_W         = $clog2(MAX_RESULTS + 1);

    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 6;
    localparam int STATUS_W = 2;
    localparam int TIME_W   = 32;

    localparam logic [TIME_W-1:0] TIME_ONES = '1;

    typedef enum logic [FUNC_W-1:0] {
        FN_CREATE     = 3'd0,
        FN_ACTIVATE   = 3'd1,
        FN_DEACTIVATE = 3'd2,
        FN_ARM        = 3'd3,
        FN_QUERY      = 3'd4,
        FN_TICK       = 3'd5,
        FN_SCAN       = 3'd6
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        STS_OK       = 2'd0,
        STS_NO_FREE  = 2'd1,
        STS_BAD_SLOT = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_EXEC,
        ST_QUERY_RD,
        ST_QUERY_SUB,
        ST_QUERY_EVAL,
        ST_CREATE,
        ST_SCAN_RD,
        ST_SCAN_EVAL,
        ST_SCAN_END
    } state_t;

    typedef struct packed {
        status_t             status;
        logic [SLOT_W-1:0]   slot_id;
        logic                fired;
        logic [TIME_W-1:0]   remaining;
        logic                last;
    } res_t;

endpackage

`default_nettype wire

// ----- design/ett_if.sv -----
`default_nettype none

interface ett_req_if import ett_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [FUNC_W-1:0]   func;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   delay_ms;

    modport source (output valid, output func, output slot, output delay_ms, input ready);
    modport sink   (input valid, input func, input slot, input delay_ms, output ready);
endinterface

interface ett_rsp_if import ett_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot_id;
    logic                fired;
    logic [TIME_W-1:0]   remaining;
    logic [TIME_W-1:0]   tick_now;
    logic                last;

    modport source (output valid, output status, output slot_id, output fired,
                    output remaining, output tick_now, output last, input ready);
    modport sink   (input valid, input status, input slot_id, input fired,
                    input remaining, input tick_now, input last, output ready);
endinterface

`default_nettype wire

// ----- design/event_timer_table.sv -----
// Channel  Dir  Payload                                          Handshake
// req      in   func, slot, delay_ms                             valid/ready
// rsp      out  status, slot_id, fired, remaining, tick_now, last valid/ready
//
// One request at a time. Activate, deactivate, arm, tick and bad ids: one execute state.
// Query: timer RAM read, subtract, compare. Create: walks the slot flags from
// slot 0, one slot flag per cycle. Scan: idle slots are skipped at the read state
// and each active slot is read, then evaluated, an order set by the single RAM read port.
// Reset clears the count and all slot flags at once; the timer RAM is not cleared.
// A stalled rsp holds the output register; the next request is taken meanwhile.
`default_nettype none
`include "event_timer_table_macros.svh"

module event_timer_table import ett_pkg::*; #(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    ett_req_if.sink   req,
    ett_rsp_if.source rsp
);

    localparam int IDX_W   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SLOT_XW = SLOT_W + 1;
    localparam logic [IDX_W-1:0]   LAST_IDX    = IDX_W'(SLOTS - 1);
    localparam logic [SLOT_XW-1:0] SLOTS_BOUND = SLOT_XW'(SLOTS);
    localparam logic [CNT_W-1:0]   CNT_LAST    = CNT_W'(MAX_RESULTS - 1);

    state_t              state_reg, state_next;
    logic [FUNC_W-1:0]   req_func_reg;
    logic [SLOT_W-1:0]   req_slot_reg;
    logic [TIME_W-1:0]   req_delay_reg;
    logic [TIME_W-1:0]   ms_reg, ms_next;
    logic [SLOTS-1:0]    used_reg, used_next;
    logic [SLOTS-1:0]    active_reg, active_next;
    logic [IDX_W-1:0]    idx_reg, idx_next;
    logic [CNT_W-1:0]    cnt_reg, cnt_next;
    logic                hold_valid_reg, hold_valid_next;
    logic [IDX_W-1:0]    hold_id_reg, hold_id_next;
    logic [TIME_W-1:0]   elapsed_reg, elapsed_next;
    logic [TIME_W-1:0]   rem_delay_reg, rem_delay_next;
    logic                out_valid_reg, out_valid_next;
    res_t                out_res_reg, out_res_next;
    logic [TIME_W-1:0]   out_tick_reg, out_tick_next;

    // Timer RAM: {start, delay} per slot.
    logic [2*TIME_W-1:0] tmr_mem [SLOTS];
    logic [2*TIME_W-1:0] rd_data_reg;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [2*TIME_W-1:0] mem_wdata;
    logic                rd_en;
    logic [IDX_W-1:0]    rd_addr;

    logic                emit;
    res_t                res;
    logic                out_free;
    logic                slot_ok;
    logic                in_slot_ok;
    logic [IDX_W-1:0]    slot_idx;
    logic [TIME_W-1:0]   rd_start;
    logic [TIME_W-1:0]   rd_delay;
    logic [TIME_W-1:0]   scan_elapsed;
    logic                scan_expired;
    logic                idx_at_last;
    func_t               func_sel;

    assign out_free     = !out_valid_reg || rsp.ready;
    assign slot_ok      = {1'b0, req_slot_reg} < SLOTS_BOUND;
    assign in_slot_ok   = {1'b0, req.slot} < SLOTS_BOUND;
    assign slot_idx     = req_slot_reg[IDX_W-1:0];
    assign rd_start     = rd_data_reg[2*TIME_W-1:TIME_W];
    assign rd_delay     = rd_data_reg[TIME_W-1:0];
    assign scan_elapsed = ms_reg - rd_start;
    assign scan_expired = scan_elapsed >= rd_delay;
    assign idx_at_last  = idx_reg == LAST_IDX;
    assign func_sel     = func_t'(req_func_reg);

    assign req.ready     = state_reg == ST_IDLE;
    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_res_reg.status;
    assign rsp.slot_id   = out_res_reg.slot_id;
    assign rsp.fired     = out_res_reg.fired;
    assign rsp.remaining = out_res_reg.remaining;
    assign rsp.tick_now  = out_tick_reg;
    assign rsp.last      = out_res_reg.last;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    unique case (func_t'(req.func))
                        FN_CREATE: state_next = ST_CREATE;
                        FN_QUERY:  state_next = in_slot_ok ? ST_QUERY_RD : ST_EXEC;
                        FN_SCAN:   state_next = ST_SCAN_RD;
                        default:   state_next = ST_EXEC;
                    endcase
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_QUERY_RD:  state_next = ST_QUERY_SUB;
            ST_QUERY_SUB: state_next = ST_QUERY_EVAL;
            ST_QUERY_EVAL:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            ST_CREATE:
            begin
                if ((!used_reg[idx_reg] || idx_at_last) && out_free)
                    state_next = ST_IDLE;
            end
            ST_SCAN_RD:
            begin
                if (active_reg[idx_reg])
                    state_next = ST_SCAN_EVAL;
                else if (idx_at_last)
                    state_next = ST_SCAN_END;
            end
            ST_SCAN_EVAL:
            begin
                if (!scan_expired)
                    state_next = idx_at_last ? ST_SCAN_END : ST_SCAN_RD;
                else if (!hold_valid_reg || out_free)
                    state_next = (cnt_reg == CNT_LAST || idx_at_last) ? ST_SCAN_END
                                                                       : ST_SCAN_RD;
            end
            ST_SCAN_END:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        ms_next         = ms_reg;
        used_next       = used_reg;
        active_next     = active_reg;
        idx_next        = idx_reg;
        cnt_next        = cnt_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        elapsed_next    = elapsed_reg;
        rem_delay_next  = rem_delay_reg;
        mem_we          = 1'b0;
        mem_waddr       = slot_idx;
        mem_wdata       = {ms_reg, req_delay_reg};
        rd_en           = 1'b0;
        rd_addr         = idx_reg;
        emit            = 1'b0;
        res             = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    idx_next        = '0;
                    cnt_next        = '0;
                    hold_valid_next = 1'b0;
                end
            end
            ST_EXEC:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    res.last = 1'b1;
                    case (func_sel) inside
                        FN_ACTIVATE, FN_ARM:
                        begin
                            if (!slot_ok)
                                res.status = STS_BAD_SLOT;
                            else
                            begin
                                mem_we    = 1'b1;
                                mem_wdata = {ms_reg,
                                             (func_sel == FN_ARM) ? req_delay_reg : '0};
                                used_next[slot_idx]   = 1'b1;
                                active_next[slot_idx] = 1'b1;
                            end
                        end
                        FN_DEACTIVATE:
                        begin
                            if (!slot_ok)
                                res.status = STS_BAD_SLOT;
                            else
                            begin
                                used_next[slot_idx]   = 1'b1;
                                active_next[slot_idx] = 1'b0;
                            end
                        end
                        FN_QUERY:
                        begin
                            res.status    = STS_BAD_SLOT;
                            res.remaining = TIME_ONES;
                        end
                        FN_TICK: ms_next = ms_reg + 32'd1;
                        default: ;
                    endcase
                end
            end
            ST_QUERY_RD:
            begin
                rd_en   = 1'b1;
                rd_addr = slot_idx;
            end
            ST_QUERY_SUB:
            begin
                elapsed_next   = ms_reg - rd_start;
                rem_delay_next = rd_delay;
            end
            ST_QUERY_EVAL:
            begin
                if (out_free)
                begin
                    emit          = 1'b1;
                    res.last      = 1'b1;
                    res.remaining = (active_reg[slot_idx] && rem_delay_reg > elapsed_reg)
                                    ? rem_delay_reg - elapsed_reg : TIME_ONES;
                end
            end
            ST_CREATE:
            begin
                if (!used_reg[idx_reg])
                begin
                    if (out_free)
                    begin
                        emit               = 1'b1;
                        res.last           = 1'b1;
                        res.slot_id        = SLOT_W'(idx_reg);
                        used_next[idx_reg] = 1'b1;
                    end
                end
                else if (idx_at_last)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        res.last   = 1'b1;
                        res.status = STS_NO_FREE;
                    end
                end
                else
                    idx_next = idx_reg + 1'b1;
            end
            ST_SCAN_RD:
            begin
                if (active_reg[idx_reg])
                    rd_en = 1'b1;
                else if (!idx_at_last)
                    idx_next = idx_reg + 1'b1;
            end
            ST_SCAN_EVAL:
            begin
                if (!scan_expired)
                begin
                    if (!idx_at_last)
                        idx_next = idx_reg + 1'b1;
                end
                else if (!hold_valid_reg || out_free)
                begin
                    // Release the previous hit now that a later one is known.
                    if (hold_valid_reg)
                    begin
                        emit        = 1'b1;
                        res.slot_id = SLOT_W'(hold_id_reg);
                        res.fired   = 1'b1;
                    end
                    hold_valid_next = 1'b1;
                    hold_id_next    = idx_reg;
                    cnt_next        = cnt_reg + 1'b1;
                    if (!idx_at_last)
                        idx_next = idx_reg + 1'b1;
                end
            end
            ST_SCAN_END:
            begin
                if (out_free)
                begin
                    emit     = 1'b1;
                    res.last = 1'b1;
                    if (hold_valid_reg)
                    begin
                        res.slot_id = SLOT_W'(hold_id_reg);
                        res.fired   = 1'b1;
                    end
                    hold_valid_next = 1'b0;
                end
            end
            default: ;
        endcase

        out_valid_next = emit ? 1'b1 : (rsp.ready ? 1'b0 : out_valid_reg);
        out_res_next   = emit ? res : out_res_reg;
        out_tick_next  = emit ? ms_next : out_tick_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            ms_reg         <= '0;
            used_reg       <= '0;
            active_reg     <= '0;
            idx_reg        <= '0;
            cnt_reg        <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            ms_reg         <= ms_next;
            used_reg       <= used_next;
            active_reg     <= active_next;
            idx_reg        <= idx_next;
            cnt_reg        <= cnt_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            req_func_reg  <= req.func;
            req_slot_reg  <= req.slot;
            req_delay_reg <= req.delay_ms;
        end
        hold_id_reg   <= hold_id_next;
        elapsed_reg   <= elapsed_next;
        rem_delay_reg <= rem_delay_next;
        out_res_reg   <= out_res_next;
        out_tick_reg  <= out_tick_next;
    end

    // Writes land before any later request can read the entry: no forwarding.
    always_ff @(posedge clk)
    begin
        if (mem_we)
            tmr_mem[mem_waddr] <= mem_wdata;
        if (rd_en)
            rd_data_reg <= tmr_mem[rd_addr];
    end

    `ETT_ASSERT_NOW(a_active_used, 1'b1, (active_reg & ~used_reg) == '0,
        "active slot not marked used")
    `ETT_ASSERT_NOW(a_walk_range,
        state_reg == ST_CREATE || state_reg == ST_SCAN_RD || state_reg == ST_SCAN_EVAL,
        idx_reg <= LAST_IDX, "slot walk index past last slot")
    `ETT_ASSERT_NOW(a_scan_cap, state_reg == ST_SCAN_RD || state_reg == ST_SCAN_EVAL,
        cnt_reg < CNT_W'(MAX_RESULTS), "scan kept walking after result cap")
    `ETT_ASSERT_NOW(a_hold_count, hold_valid_reg, cnt_reg != '0,
        "held scan hit without a hit count")
    `ETT_ASSERT_NEXT(a_ms_step, 1'b1,
        ms_reg == $past(ms_reg) || ms_reg == $past(ms_reg) + 32'd1,
        "millisecond count moved by more than one")

endmodule

`default_nettype wire
